/* sv/srpd_pkg.sv */
// Shared types and constants for the sensor reply packet deframer.
package srpd_pkg;

  // Frame layout and limits.
  localparam logic [7:0] HDR_FIRST   = 8'hEF;
  localparam logic [7:0] HDR_SECOND  = 8'h01;
  localparam int         HEAD_BYTES  = 9;
  localparam logic [4:0] BODY_RESET  = 5'd23;
  localparam int         STORE_BYTES = 32;

  // The reported fields live at offsets 6 through 13 of the frame store.
  localparam int FIELD_BASE  = 6;
  localparam int FIELD_BYTES = 8;

  // Input actions.
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_CLEAR   = 1'b1;

  typedef struct packed {
    logic       action;
    logic       byte_valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        byte_stored;
    logic [4:0]  byte_offset;
    logic        frame_done;
    logic        frame_dropped;
    logic        reply_ready;
    logic [7:0]  packet_id;
    logic [4:0]  body_length;
    logic [7:0]  confirm_code;
    logic [15:0] first_word;
    logic [15:0] second_word;
  } out_item_t;

endpackage

/* sv/srpd_parser.sv */
// Frame parser state, captured reply fields and the per-byte result logic.
module srpd_parser #(
  parameter int STORE_BYTES = srpd_pkg::STORE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  srpd_pkg::in_item_t item,
  input  logic [4:0]         max_len,
  output srpd_pkg::out_item_t result
);

  localparam int OW = $clog2(STORE_BYTES + 1);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HDR2,
    ST_FIELDS,
    ST_BODY
  } step_t;

  step_t       st, st_next;
  logic [OW-1:0] off, off_next;
  logic [4:0]  flen, flen_next;
  logic        rdy, rdy_next;
  logic [7:0]  fld      [srpd_pkg::FIELD_BYTES];
  logic [7:0]  fld_next [srpd_pkg::FIELD_BYTES];

  logic          stored;
  logic          done;
  logic          dropped;
  logic [OW-1:0] wr_off;
  logic [OW-1:0] off_inc;
  logic [OW:0]   end_off;
  logic [15:0]   len16;

  assign off_inc = off + OW'(1);
  assign end_off = (OW+1)'(srpd_pkg::HEAD_BYTES) + (OW+1)'(flen);
  assign len16   = {fld[1], item.rx_byte};

  // Next state and the result flags for the byte held in the input register.
  always_comb begin
    st_next   = st;
    off_next  = off;
    flen_next = flen;
    rdy_next  = rdy;
    for (int i = 0; i < srpd_pkg::FIELD_BYTES; i++) begin
      fld_next[i] = fld[i];
    end
    stored  = 1'b0;
    done    = 1'b0;
    dropped = 1'b0;
    wr_off  = '0;

    if (item.action == srpd_pkg::ACT_CLEAR) begin
      st_next   = ST_HUNT;
      off_next  = '0;
      flen_next = '0;
      rdy_next  = 1'b0;
      for (int i = 0; i < srpd_pkg::FIELD_BYTES; i++) begin
        fld_next[i] = '0;
      end
    end else if (item.byte_valid) begin
      case (st)
        ST_HUNT: begin
          if (item.rx_byte == srpd_pkg::HDR_FIRST) begin
            stored  = 1'b1;
            wr_off  = '0;
            st_next = ST_HDR2;
          end
        end
        ST_HDR2: begin
          if (item.rx_byte == srpd_pkg::HDR_SECOND) begin
            stored    = 1'b1;
            wr_off    = OW'(1);
            off_next  = OW'(2);
            flen_next = '0;
            st_next   = ST_FIELDS;
          end else begin
            dropped = 1'b1;
            st_next = ST_HUNT;
          end
        end
        default: begin
          if (off >= OW'(STORE_BYTES)) begin
            dropped = 1'b1;
            st_next = ST_HUNT;
          end else begin
            stored   = 1'b1;
            wr_off   = off;
            off_next = off_inc;
            if (st == ST_FIELDS) begin
              if (off_inc == OW'(srpd_pkg::HEAD_BYTES)) begin
                if (len16 != 16'd0 && len16 <= {11'd0, max_len}) begin
                  flen_next = len16[4:0];
                  st_next   = ST_BODY;
                end else begin
                  flen_next = '0;
                  dropped   = 1'b1;
                  st_next   = ST_HUNT;
                end
              end
            end else if ({1'b0, off_inc} == end_off) begin
              rdy_next = 1'b1;
              done     = 1'b1;
              st_next  = ST_HUNT;
            end
          end
        end
      endcase
    end

    // Only the reported offsets keep their bytes.
    if (stored) begin
      for (int i = 0; i < srpd_pkg::FIELD_BYTES; i++) begin
        if (wr_off == OW'(srpd_pkg::FIELD_BASE + i)) begin
          fld_next[i] = item.rx_byte;
        end
      end
    end
  end

  // The result shows the state after this byte.
  always_comb begin
    result.byte_stored   = stored;
    result.byte_offset   = wr_off[4:0];
    result.frame_done    = done;
    result.frame_dropped = dropped;
    result.reply_ready   = rdy_next;
    result.packet_id     = fld_next[0];
    result.body_length   = flen_next;
    result.confirm_code  = fld_next[3];
    result.first_word    = {fld_next[4], fld_next[5]};
    result.second_word   = {fld_next[6], fld_next[7]};
  end

  // Parser state and captured fields advance once per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_HUNT;
      off  <= '0;
      flen <= '0;
      rdy  <= 1'b0;
      for (int i = 0; i < srpd_pkg::FIELD_BYTES; i++) begin
        fld[i] <= '0;
      end
    end else if (step) begin
      st   <= st_next;
      off  <= off_next;
      flen <= flen_next;
      rdy  <= rdy_next;
      for (int i = 0; i < srpd_pkg::FIELD_BYTES; i++) begin
        fld[i] <= fld_next[i];
      end
    end
  end

`ifndef SYNTH
  // A completed frame leaves the ready flag set.
  a_done_sets_ready: assert property (@(posedge clk) disable iff (rst)
    step && done |=> rdy)
    else $error("ready flag not set after frame completion");

  // The body phase always has a nonzero accepted length.
  a_body_len: assert property (@(posedge clk) disable iff (rst)
    st == ST_BODY |-> flen != 5'd0)
    else $error("body phase with zero length");

  // The write offset never runs past the store.
  a_off_bound: assert property (@(posedge clk) disable iff (rst)
    off <= OW'(STORE_BYTES))
    else $error("write offset beyond store");

  // A clear returns the parser to hunting with the flag low.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    step && item.action == srpd_pkg::ACT_CLEAR |=> st == ST_HUNT && !rdy && flen == 5'd0)
    else $error("clear did not reset parser");
`endif

endmodule

/* sv/sensor_reply_packet_deframer.sv */
// An accepted input transaction is registered in the input register, and its result then in the result register.
// Throughput: one received byte per cycle, with no stall unless the output is held.
// Each byte is handled by one pass of logic from the input register into the result register.
// Reset clears the parser, the ready flag, the captured fields and the valid flags of both register stages,
// and sets max_len back to 23.
module sensor_reply_packet_deframer #(
  parameter int STORE_BYTES = srpd_pkg::STORE_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  srpd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output srpd_pkg::out_item_t out_item
);

  logic                s1_valid;
  srpd_pkg::in_item_t  s1_item;
  logic [4:0]          max_len;
  logic                adv;
  srpd_pkg::out_item_t result;

  // The input stage moves forward whenever the result register is free or drains.
  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;

  srpd_parser #(
    .STORE_BYTES(STORE_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && adv),
    .item   (s1_item),
    .max_len(max_len),
    .result (result)
  );

  // Control registers and the length limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      max_len   <= srpd_pkg::BODY_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Payload registers for the input and result stages.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (adv && s1_valid) begin
      out_item <= result;
    end
  end

endmodule
